// ----- rtl/core/warnsdorff_grid_walk_3d_macros.svh -----
// Assertion macros used by the checker file.
`ifndef WARNSDORFF_GRID_WALK_3D_MACROS_SVH
`define WARNSDORFF_GRID_WALK_3D_MACROS_SVH

// Plain clocked check, disabled while reset is applied.
`define WGW_ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("warnsdorff walk check failed");

// Same-cycle implication.
`define WGW_ASSERT_IMP(lbl, ante, cons) \
    `WGW_ASSERT_CLK(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define WGW_ASSERT_NXT(lbl, ante, cons) \
    `WGW_ASSERT_CLK(lbl, (ante) |=> (cons))

`endif

// ----- rtl/core/wgw_pkg.sv -----
package wgw_pkg;

    localparam int POS_W    = 4;
    localparam int STEP_W   = 13;
    localparam int STATUS_W = 3;
    localparam int SIDE_W   = 5;
    localparam int DEG_W    = 3;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic REG_SIDE_LENGTH = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_MOVED     = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_STUCK     = 3'd2,
        ST_NO_WALK   = 3'd3,
        ST_START_OUT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        DIR_XP   = 3'd0,
        DIR_XN   = 3'd1,
        DIR_YP   = 3'd2,
        DIR_YN   = 3'd3,
        DIR_ZP   = 3'd4,
        DIR_ZN   = 3'd5,
        DIR_SELF = 3'd6
    } dir_t;

    typedef struct packed {
        logic              visited;
        logic [DEG_W-1:0]  degree;
    } cell_t;

    typedef struct packed {
        logic en;
        logic we;
    } mem_ctl_t;

endpackage

// ----- rtl/core/wgw_if.sv -----
interface wgw_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [wgw_pkg::POS_W-1:0]  start_x;
    logic [wgw_pkg::POS_W-1:0]  start_y;
    logic [wgw_pkg::POS_W-1:0]  start_z;

    modport source (output valid, output opcode, output start_x, output start_y,
                    output start_z, input ready);
    modport sink (input valid, input opcode, input start_x, input start_y,
                  input start_z, output ready);
endinterface

interface wgw_out_if;
    logic                         valid;
    logic                         ready;
    logic [wgw_pkg::POS_W-1:0]    pos_x;
    logic [wgw_pkg::POS_W-1:0]    pos_y;
    logic [wgw_pkg::POS_W-1:0]    pos_z;
    logic [wgw_pkg::STEP_W-1:0]   step_number;
    logic [wgw_pkg::STATUS_W-1:0] status;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output step_number, output status, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input step_number, input status, output ready);
endinterface

// ----- rtl/core/warnsdorff_grid_walk_3d.sv -----
// Channel   Dir   Beat contents
// in_ch     in    opcode, start_x, start_y, start_z
// out_ch    out   pos_x, pos_y, pos_z, step_number, status
// APB       in    side_length at byte address 0
//
// An advance uses one single-port cell memory, read once per in-grid neighbour
// in the scan; in the visit each in-grid neighbour is read and, if unvisited
// with a nonzero degree, written back with its degree less one. A restart in
// the grid sweeps all N cubed cells, then visits the start cell.
// Reset sets side_length to 5 and leaves no active walk.
// in_ch is ready only between items; a result waits in the output register
// while the next beat is accepted.
module warnsdorff_grid_walk_3d #(
    parameter int MAX_SIDE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    wgw_in_if.sink      in_ch,
    wgw_out_if.source   out_ch
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(DEPTH + 1);
    localparam int CLW   = ((SW > wgw_pkg::SIDE_W) ? SW : wgw_pkg::SIDE_W) + 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SWEEP = 10'b00_0000_0010,
        S_VMARK = 10'b00_0000_0100,
        S_VRD   = 10'b00_0000_1000,
        S_VWT   = 10'b00_0001_0000,
        S_VEND  = 10'b00_0010_0000,
        S_SRD   = 10'b00_0100_0000,
        S_SCHK  = 10'b00_1000_0000,
        S_SEND  = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    wgw_pkg::dir_t                   dir_reg, dir_next;
    logic [CW-1:0]                   cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [CW-1:0]                   sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next;
    logic [CW-1:0]                   bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic [wgw_pkg::STEP_W-1:0]      steps_reg, steps_next;
    logic                            active_reg, active_next;
    logic [wgw_pkg::SIDE_W-1:0]      side_reg, side_next;
    logic [SW-1:0]                   wside_reg, wside_next;
    logic [KW-1:0]                   cube_reg, cube_next;
    logic                            found_reg, found_next;
    logic [wgw_pkg::DEG_W-1:0]       bdeg_reg, bdeg_next;
    wgw_pkg::status_t                status_reg, status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [wgw_pkg::POS_W-1:0]       out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [wgw_pkg::POS_W-1:0]       out_z_reg, out_z_next;
    logic [wgw_pkg::STEP_W-1:0]      out_step_reg, out_step_next;
    logic [wgw_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [CW-1:0]                   nb_x, nb_y, nb_z;
    wgw_pkg::dir_t                   nb_dir;
    logic                            nb_ok;
    logic [CW-1:0]                   nb_nx, nb_ny, nb_nz;
    logic [AW-1:0]                   nb_addr;
    wgw_pkg::mem_ctl_t               mem_ctl;
    wgw_pkg::cell_t                  mem_wdata, mem_rdata;

    logic [CLW-1:0]                  side_ext;
    logic [SW-1:0]                   side_clamped;
    logic                            start_in_grid;
    logic [CW:0]                     side_w, sxp, syp, szp;
    logic [wgw_pkg::DEG_W-1:0]       sweep_deg;
    logic                            cfg_write;
    logic                            last_dir;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == wgw_pkg::REG_SIDE_LENGTH);
    assign prdata    = (paddr[2] == wgw_pkg::REG_SIDE_LENGTH)
                       ? {{(32 - wgw_pkg::SIDE_W){1'b0}}, side_reg} : '0;

    assign side_ext = CLW'(side_reg);

    always_comb
    begin
        if (side_reg == '0)
        begin
            side_clamped = SW'(1);
        end
        else if (side_ext > CLW'(MAX_SIDE))
        begin
            side_clamped = SW'(MAX_SIDE);
        end
        else
        begin
            side_clamped = SW'(side_reg);
        end
    end

    assign start_in_grid = ((SW + 4)'(in_ch.start_x) < (SW + 4)'(side_clamped))
                        && ((SW + 4)'(in_ch.start_y) < (SW + 4)'(side_clamped))
                        && ((SW + 4)'(in_ch.start_z) < (SW + 4)'(side_clamped));

    assign side_w = (CW + 1)'(wside_reg);
    assign sxp    = {1'b0, sx_reg} + 1'b1;
    assign syp    = {1'b0, sy_reg} + 1'b1;
    assign szp    = {1'b0, sz_reg} + 1'b1;

    // A cell's degree is its count of in-grid axis neighbours.
    assign sweep_deg = {2'b00, (sx_reg != '0)} + {2'b00, (sxp < side_w)}
                     + {2'b00, (sy_reg != '0)} + {2'b00, (syp < side_w)}
                     + {2'b00, (sz_reg != '0)} + {2'b00, (szp < side_w)};

    assign nb_x   = (state_reg == S_SWEEP) ? sx_reg : cx_reg;
    assign nb_y   = (state_reg == S_SWEEP) ? sy_reg : cy_reg;
    assign nb_z   = (state_reg == S_SWEEP) ? sz_reg : cz_reg;
    assign nb_dir = ((state_reg == S_SWEEP) || (state_reg == S_VMARK))
                    ? wgw_pkg::DIR_SELF : dir_reg;

    assign last_dir = dir_reg == wgw_pkg::DIR_ZN;

    wgw_nbr #(
        .MAX_SIDE(MAX_SIDE)
    ) u_nbr (
        .x    (nb_x),
        .y    (nb_y),
        .z    (nb_z),
        .dir  (nb_dir),
        .side (wside_reg),
        .ok   (nb_ok),
        .nx   (nb_nx),
        .ny   (nb_ny),
        .nz   (nb_nz),
        .addr (nb_addr)
    );

    wgw_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (nb_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign in_ch.ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        sz_next         = sz_reg;
        bx_next         = bx_reg;
        by_next         = by_reg;
        bz_next         = bz_reg;
        steps_next      = steps_reg;
        active_next     = active_reg;
        side_next       = cfg_write ? pwdata[wgw_pkg::SIDE_W-1:0] : side_reg;
        wside_next      = wside_reg;
        cube_next       = cube_reg;
        found_next      = found_reg;
        bdeg_next       = bdeg_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_z_next      = out_z_reg;
        out_step_next   = out_step_reg;
        out_status_next = out_status_reg;
        mem_ctl         = '0;
        mem_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.opcode == wgw_pkg::OP_RESTART)
                    begin
                        wside_next = side_clamped;
                        if (start_in_grid)
                        begin
                            cx_next    = CW'(in_ch.start_x);
                            cy_next    = CW'(in_ch.start_y);
                            cz_next    = CW'(in_ch.start_z);
                            sx_next    = '0;
                            sy_next    = '0;
                            sz_next    = '0;
                            cube_next  = '0;
                            steps_next = '0;
                            state_next = S_SWEEP;
                        end
                        else
                        begin
                            active_next = 1'b0;
                            status_next = wgw_pkg::ST_START_OUT;
                            state_next  = S_FIN;
                        end
                    end
                    else if (!active_reg)
                    begin
                        status_next = wgw_pkg::ST_NO_WALK;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        dir_next   = wgw_pkg::DIR_XP;
                        found_next = 1'b0;
                        state_next = S_SRD;
                    end
                end
            end
            S_SWEEP:
            begin
                mem_ctl           = '{en: 1'b1, we: 1'b1};
                mem_wdata.visited = 1'b0;
                mem_wdata.degree  = sweep_deg;
                cube_next         = cube_reg + 1'b1;
                if (szp != side_w)
                begin
                    sz_next = szp[CW-1:0];
                end
                else
                begin
                    sz_next = '0;
                    if (syp != side_w)
                    begin
                        sy_next = syp[CW-1:0];
                    end
                    else
                    begin
                        sy_next = '0;
                        if (sxp != side_w)
                        begin
                            sx_next = sxp[CW-1:0];
                        end
                        else
                        begin
                            state_next = S_VMARK;
                        end
                    end
                end
            end
            S_VMARK:
            begin
                mem_ctl           = '{en: 1'b1, we: 1'b1};
                mem_wdata.visited = 1'b1;
                steps_next        = steps_reg + 1'b1;
                dir_next          = wgw_pkg::DIR_XP;
                state_next        = S_VRD;
            end
            S_VRD:
            begin
                if (nb_ok)
                begin
                    mem_ctl    = '{en: 1'b1, we: 1'b0};
                    state_next = S_VWT;
                end
                else if (last_dir)
                begin
                    state_next = S_VEND;
                end
                else
                begin
                    dir_next = wgw_pkg::dir_t'(dir_reg + 3'd1);
                end
            end
            S_VWT:
            begin
                if (!mem_rdata.visited && (mem_rdata.degree != '0))
                begin
                    mem_ctl           = '{en: 1'b1, we: 1'b1};
                    mem_wdata.visited = 1'b0;
                    mem_wdata.degree  = mem_rdata.degree - 1'b1;
                end
                if (last_dir)
                begin
                    state_next = S_VEND;
                end
                else
                begin
                    dir_next   = wgw_pkg::dir_t'(dir_reg + 3'd1);
                    state_next = S_VRD;
                end
            end
            S_VEND:
            begin
                if ((KW + wgw_pkg::STEP_W)'(steps_reg) == (KW + wgw_pkg::STEP_W)'(cube_reg))
                begin
                    active_next = 1'b0;
                    status_next = wgw_pkg::ST_COMPLETE;
                end
                else
                begin
                    active_next = 1'b1;
                    status_next = wgw_pkg::ST_MOVED;
                end
                state_next = S_FIN;
            end
            S_SRD:
            begin
                if (nb_ok)
                begin
                    mem_ctl    = '{en: 1'b1, we: 1'b0};
                    state_next = S_SCHK;
                end
                else if (last_dir)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    dir_next = wgw_pkg::dir_t'(dir_reg + 3'd1);
                end
            end
            S_SCHK:
            begin
                if (!mem_rdata.visited && (!found_reg || (mem_rdata.degree < bdeg_reg)))
                begin
                    found_next = 1'b1;
                    bdeg_next  = mem_rdata.degree;
                    bx_next    = nb_nx;
                    by_next    = nb_ny;
                    bz_next    = nb_nz;
                end
                if (last_dir)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    dir_next   = wgw_pkg::dir_t'(dir_reg + 3'd1);
                    state_next = S_SRD;
                end
            end
            S_SEND:
            begin
                if (!found_reg)
                begin
                    active_next = 1'b0;
                    status_next = wgw_pkg::ST_STUCK;
                    state_next  = S_FIN;
                end
                else
                begin
                    cx_next    = bx_reg;
                    cy_next    = by_reg;
                    cz_next    = bz_reg;
                    state_next = S_VMARK;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = wgw_pkg::POS_W'(cx_reg);
                    out_y_next      = wgw_pkg::POS_W'(cy_reg);
                    out_z_next      = wgw_pkg::POS_W'(cz_reg);
                    out_step_next   = (status_reg == wgw_pkg::ST_START_OUT) ? '0 : steps_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dir_reg       <= wgw_pkg::DIR_XP;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            steps_reg     <= '0;
            active_reg    <= 1'b0;
            side_reg      <= wgw_pkg::SIDE_W'(5);
            wside_reg     <= SW'(1);
            found_reg     <= 1'b0;
            status_reg    <= wgw_pkg::ST_NO_WALK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            cz_reg        <= cz_next;
            steps_reg     <= steps_next;
            active_reg    <= active_next;
            side_reg      <= side_next;
            wside_reg     <= wside_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        sz_reg         <= sz_next;
        bx_reg         <= bx_next;
        by_reg         <= by_next;
        bz_reg         <= bz_next;
        cube_reg       <= cube_next;
        bdeg_reg       <= bdeg_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_z_reg      <= out_z_next;
        out_step_reg   <= out_step_next;
        out_status_reg <= out_status_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.pos_x       = out_x_reg;
    assign out_ch.pos_y       = out_y_reg;
    assign out_ch.pos_z       = out_z_reg;
    assign out_ch.step_number = out_step_reg;
    assign out_ch.status      = out_status_reg;

endmodule

// ----- rtl/core/wgw_mem.sv -----
module wgw_mem #(
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  wgw_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  wgw_pkg::cell_t    wdata,
    output wgw_pkg::cell_t    rdata
);

    wgw_pkg::cell_t mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- rtl/core/wgw_nbr.sv -----
module wgw_nbr #(
    parameter int MAX_SIDE = 16,
    localparam int CW = $clog2(MAX_SIDE),
    localparam int SW = $clog2(MAX_SIDE + 1),
    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE * MAX_SIDE)
) (
    input  logic [CW-1:0]   x,
    input  logic [CW-1:0]   y,
    input  logic [CW-1:0]   z,
    input  wgw_pkg::dir_t   dir,
    input  logic [SW-1:0]   side,
    output logic            ok,
    output logic [CW-1:0]   nx,
    output logic [CW-1:0]   ny,
    output logic [CW-1:0]   nz,
    output logic [AW-1:0]   addr
);

    localparam logic [AW-1:0] ROW_A   = AW'(MAX_SIDE);
    localparam logic [AW-1:0] PLANE_A = AW'(MAX_SIDE * MAX_SIDE);

    logic [CW:0] side_w;
    logic [CW:0] xp;
    logic [CW:0] yp;
    logic [CW:0] zp;

    assign side_w = (CW + 1)'(side);
    assign xp     = {1'b0, x} + 1'b1;
    assign yp     = {1'b0, y} + 1'b1;
    assign zp     = {1'b0, z} + 1'b1;

    always_comb
    begin
        ok = 1'b0;
        nx = x;
        ny = y;
        nz = z;
        case (dir)
            wgw_pkg::DIR_XP:
            begin
                ok = xp < side_w;
                nx = xp[CW-1:0];
            end
            wgw_pkg::DIR_XN:
            begin
                ok = x != '0;
                nx = x - 1'b1;
            end
            wgw_pkg::DIR_YP:
            begin
                ok = yp < side_w;
                ny = yp[CW-1:0];
            end
            wgw_pkg::DIR_YN:
            begin
                ok = y != '0;
                ny = y - 1'b1;
            end
            wgw_pkg::DIR_ZP:
            begin
                ok = zp < side_w;
                nz = zp[CW-1:0];
            end
            wgw_pkg::DIR_ZN:
            begin
                ok = z != '0;
                nz = z - 1'b1;
            end
            wgw_pkg::DIR_SELF:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign addr = AW'(nx) * PLANE_A + AW'(ny) * ROW_A + AW'(nz);

endmodule

// ----- rtl/core/wgw_checker.sv -----
`include "warnsdorff_grid_walk_3d_macros.svh"

module wgw_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [wgw_pkg::STEP_W-1:0]     step_number,
    input  logic [wgw_pkg::STATUS_W-1:0]   status
);

    // A result beat stays offered until it is taken.
    `WGW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Once a beat is taken the block is busy on it in the next cycle.
    `WGW_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // Only the defined status codes are reported.
    `WGW_ASSERT_IMP(a_status_code, out_valid,
        (status == wgw_pkg::ST_MOVED) || (status == wgw_pkg::ST_COMPLETE)
        || (status == wgw_pkg::ST_STUCK) || (status == wgw_pkg::ST_NO_WALK)
        || (status == wgw_pkg::ST_START_OUT))

    // A rejected start reports no visited cells.
    `WGW_ASSERT_IMP(a_start_out_step, out_valid && (status == wgw_pkg::ST_START_OUT),
        step_number == '0)

endmodule

bind warnsdorff_grid_walk_3d wgw_checker u_wgw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .step_number (out_ch.step_number),
    .status      (out_ch.status)
);
